@@ design/pbra_pkg.sv @@
package pbra_pkg;

  localparam int NUM_PAGES    = 1024;
  localparam int WORD_BITS    = 32;
  localparam int NUM_WORDS    = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int WADDR_W      = $clog2(NUM_WORDS);
  localparam int LEFT_W       = $clog2(NUM_WORDS + 1);

  localparam int OP_W         = 3;
  localparam int LEN_W        = 11;
  localparam int PIDX_W       = 10;
  localparam int KS_W         = 11;
  localparam int CNT_W        = LEN_W + 1;
  localparam int BND_W        = ($clog2(NUM_PAGES + 1) > LEN_W) ? $clog2(NUM_PAGES + 1) : LEN_W;
  localparam int START_W      = BND_W + 1;

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic [PADDR_W-3:0] REG_KSTART = '0;
  localparam logic [KS_W-1:0] KSTART_RESET = KS_W'(768);

  typedef enum logic [OP_W-1:0] {
    OP_FIND_LO    = 3'd0,
    OP_FIND_HI    = 3'd1,
    OP_MARK       = 3'd2,
    OP_FREE       = 3'd3,
    OP_FREE_RANGE = 3'd4,
    OP_QUERY      = 3'd5
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic              region;
    logic [LEN_W-1:0]  run_length;
    logic [PIDX_W-1:0] page_index;
    logic [LEN_W-1:0]  range_end;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [PIDX_W-1:0] run_start;
    logic              is_used;
  } out_t;

  typedef struct packed {
    logic                 re;
    logic [WADDR_W-1:0]   raddr;
    logic                 we;
    logic [WADDR_W-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [WADDR_W-1:0] word;
    logic               from_top;
    logic [BND_W-1:0]   lo;
    logic [BND_W-1:0]   hi;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   count;
  } scan_req_t;

  typedef struct packed {
    logic              hit;
    logic [PIDX_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } scan_rsp_t;

  // bits of word w whose pages lie in [lo, hi)
  function automatic logic [WORD_BITS-1:0] word_mask(logic [WADDR_W-1:0] w,
                                                     logic [BND_W-1:0] lo,
                                                     logic [BND_W-1:0] hi);
    logic [WORD_BITS-1:0] ones;
    logic [WORD_BITS-1:0] lm;
    logic [WORD_BITS-1:0] hm;
    ones = '1;
    if (int'(w) > int'(lo >> BIT_W)) begin
      lm = ones;
    end else if (int'(w) == int'(lo >> BIT_W)) begin
      lm = ones << lo[BIT_W-1:0];
    end else begin
      lm = '0;
    end
    if (int'(w) < int'(hi >> BIT_W)) begin
      hm = ones;
    end else if (int'(w) == int'(hi >> BIT_W)) begin
      hm = ~(ones << hi[BIT_W-1:0]);
    end else begin
      hm = '0;
    end
    return lm & hm;
  endfunction

endpackage

@@ design/pbra_store.sv @@
module pbra_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pbra_pkg::mem_req_t            req_i,
  output logic [pbra_pkg::WORD_BITS-1:0] rdata_o
);
  import pbra_pkg::*;

  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_q;
  logic [NUM_WORDS-1:0] vld_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  // per-word written flags: an unwritten word reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : '0;

endmodule

@@ design/pbra_scan.sv @@
module pbra_scan (
  input  pbra_pkg::scan_req_t           req_i,
  input  logic [pbra_pkg::WORD_BITS-1:0] used_i,
  output pbra_pkg::scan_rsp_t           rsp_o
);
  import pbra_pkg::*;

  logic [WORD_BITS-1:0] f;
  logic [WORD_BITS-1:0] v;
  logic [WORD_BITS-1:0] p;
  logic [WORD_BITS-1:0] e;
  logic [WORD_BITS-1:0] cand;
  logic [BIT_W:0]       tz;
  logic [BIT_W:0]       lz;
  logic [BIT_W:0]       l6;
  logic [BIT_W-1:0]     pos;
  logic [LEN_W-1:0]     need;
  logic                 all_free;
  logic                 a_ok;
  logic [START_W-1:0]   base;
  logic [START_W-1:0]   start;

  always_comb begin
    f = ~used_i & word_mask(req_i.word, req_i.lo, req_i.hi);
    for (int i = 0; i < WORD_BITS; i++) begin
      v[i] = req_i.from_top ? f[WORD_BITS-1-i] : f[i];
    end

    // free pages at the scan-entry end and at the far end of the word
    tz = (BIT_W+1)'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) tz = (BIT_W+1)'(i);
    end
    lz = (BIT_W+1)'(WORD_BITS);
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!v[i]) lz = (BIT_W+1)'(WORD_BITS - 1 - i);
    end
    all_free = &v;

    // run continued from earlier words
    need = req_i.len - req_i.count;
    a_ok = (int'(need) <= WORD_BITS) && (int'(tz) >= int'(need));

    // runs inside the word: erosion by the binary digits of len
    l6 = req_i.len[BIT_W:0];
    p  = v;
    e  = '1;
    for (int b = 0; b <= BIT_W; b++) begin
      if (l6[b]) e = e & (p << (l6 & (BIT_W+1)'((1 << b) - 1)));
      p = p & (p << (1 << b));
    end
    if (int'(req_i.len) > WORD_BITS) e = '0;

    cand = e | (a_ok ? (WORD_BITS'(1) << (need - LEN_W'(1))) : '0);
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) pos = BIT_W'(i);
    end

    base = START_W'(req_i.word) << BIT_W;
    if (req_i.from_top) begin
      start = base + START_W'(WORD_BITS - 1) - START_W'(pos);
    end else begin
      start = base + START_W'(pos) + START_W'(1) - START_W'(req_i.len);
    end

    rsp_o.hit   = |cand;
    rsp_o.start = start[PIDX_W-1:0];
    rsp_o.count = all_free ? (CNT_W'(req_i.count) + CNT_W'(WORD_BITS)) : CNT_W'(lz);
  end

endmodule

@@ design/page_bitmap_run_allocator.sv @@
// Mark, free page and query (page in range) read the bitmap word, then write it or take
// the result; find reads the words in turn until a run is found or all NUM_WORDS are read;
// free range: one word per cycle over the words it touches; an empty range or an unknown
// operation goes straight to the result. One transaction at a time: the next is accepted
// in the cycle after the result register loads, and a stalled result holds the input off.
// Reset: all pages free at once through per-word written flags, kernel_region_start = 768.
module page_bitmap_run_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pbra_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pbra_pkg::out_t                   out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pbra_pkg::PADDR_W-1:0]     paddr,
  input  logic [pbra_pkg::PDATA_W-1:0]     pwdata,
  output logic [pbra_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);
  import pbra_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]           state_q, state_d;
  op_e                  op_q, op_d;
  logic [BND_W-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [LEN_W-1:0]     len_q, len_d, count_q, count_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [WADDR_W-1:0]   rd_addr_q, rd_addr_d, ev_addr_q, ev_addr_d;
  logic [LEFT_W-1:0]    rd_left_q, rd_left_d;
  logic                 pend_q, pend_d;
  out_t                 res_q, res_d, out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [KS_W-1:0]      kstart_q, kstart_d;

  mem_req_t             mreq;
  logic [WORD_BITS-1:0] rdata;
  scan_req_t            sreq;
  scan_rsp_t            srsp;

  logic                 accept, issue, finish, load_out, cfg_wr;
  logic [LEN_W-1:0]     len_in;
  logic [BND_W-1:0]     bnd, page_b, rend_c;
  logic [WADDR_W-1:0]   first_w, last_w;
  logic                 page_ok;

  pbra_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  pbra_scan u_scan (
    .req_i  (sreq),
    .used_i (rdata),
    .rsp_o  (srsp)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_KSTART);
  assign prdata  = (paddr[PADDR_W-1:2] == REG_KSTART) ? PDATA_W'(kstart_q) : '0;
  assign kstart_d = cfg_wr ? pwdata[KS_W-1:0] : kstart_q;

  assign len_in  = (in_data_i.run_length == '0) ? LEN_W'(1) : in_data_i.run_length;
  assign bnd     = (int'(kstart_q) > NUM_PAGES) ? BND_W'(NUM_PAGES) : BND_W'(kstart_q);
  assign page_b  = BND_W'(in_data_i.page_index);
  assign rend_c  = (int'(in_data_i.range_end) > NUM_PAGES) ? BND_W'(NUM_PAGES)
                                                           : BND_W'(in_data_i.range_end);
  assign page_ok = int'(in_data_i.page_index) < NUM_PAGES;
  assign first_w = WADDR_W'(page_b >> BIT_W);
  assign last_w  = WADDR_W'((rend_c - BND_W'(1)) >> BIT_W);

  assign sreq.word     = ev_addr_q;
  assign sreq.from_top = (op_q == OP_FIND_HI);
  assign sreq.lo       = lo_q;
  assign sreq.hi       = hi_q;
  assign sreq.len      = len_q;
  assign sreq.count    = count_q;

  assign issue = (state_q == ST_SWEEP) && (rd_left_q != '0);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    len_d       = len_q;
    count_d     = count_q;
    bit_d       = bit_q;
    rd_addr_d   = rd_addr_q;
    rd_left_d   = rd_left_q;
    ev_addr_d   = ev_addr_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    finish      = 1'b0;

    mreq.re    = issue;
    mreq.raddr = rd_addr_q;
    mreq.we    = 1'b0;
    mreq.waddr = ev_addr_q;
    mreq.wdata = rdata;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d      = op_e'(in_data_i.operation);
          len_d     = len_in;
          bit_d     = in_data_i.page_index[BIT_W-1:0];
          count_d   = '0;
          res_d     = '0;
          rd_addr_d = first_w;
          rd_left_d = LEFT_W'(1);
          state_d   = ST_DONE;
          case (in_data_i.operation)
            OP_FIND_LO, OP_FIND_HI: begin
              lo_d      = in_data_i.region ? bnd : '0;
              hi_d      = in_data_i.region ? BND_W'(NUM_PAGES) : bnd;
              rd_addr_d = (in_data_i.operation == OP_FIND_HI) ? WADDR_W'(NUM_WORDS - 1) : '0;
              rd_left_d = LEFT_W'(NUM_WORDS);
              state_d   = ST_SWEEP;
            end
            OP_MARK, OP_FREE, OP_QUERY: begin
              if (page_ok) state_d = ST_SWEEP;
            end
            OP_FREE_RANGE: begin
              lo_d      = page_b;
              hi_d      = rend_c;
              rd_left_d = LEFT_W'(int'(last_w) - int'(first_w) + 1);
              if (rend_c > page_b) state_d = ST_SWEEP;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (issue) begin
          rd_left_d = rd_left_q - LEFT_W'(1);
          rd_addr_d = (op_q == OP_FIND_HI) ? (rd_addr_q - WADDR_W'(1))
                                           : (rd_addr_q + WADDR_W'(1));
        end
        if (pend_q) begin
          case (op_q)
            OP_FIND_LO, OP_FIND_HI: begin
              if (srsp.hit) begin
                res_d.found     = 1'b1;
                res_d.run_start = srsp.start;
                finish          = 1'b1;
              end else begin
                count_d = srsp.count[LEN_W-1:0];
                finish  = !issue;
              end
            end
            OP_MARK: begin
              mreq.we    = 1'b1;
              mreq.wdata = rdata | (WORD_BITS'(1) << bit_q);
              finish     = 1'b1;
            end
            OP_FREE: begin
              mreq.we    = 1'b1;
              mreq.wdata = rdata & ~(WORD_BITS'(1) << bit_q);
              finish     = 1'b1;
            end
            OP_FREE_RANGE: begin
              mreq.we    = 1'b1;
              mreq.wdata = rdata & ~word_mask(ev_addr_q, lo_q, hi_q);
              finish     = !issue;
            end
            OP_QUERY: begin
              res_d.is_used = rdata[bit_q];
              finish        = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
        ev_addr_d = rd_addr_q;
        if (finish) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign pend_d = issue && !finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      rd_left_q   <= '0;
      out_valid_q <= 1'b0;
      kstart_q    <= KSTART_RESET;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      rd_left_q   <= rd_left_d;
      out_valid_q <= out_valid_d;
      kstart_q    <= kstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    len_q     <= len_d;
    count_q   <= count_d;
    bit_q     <= bit_d;
    rd_addr_q <= rd_addr_d;
    ev_addr_q <= ev_addr_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  a_no_rw_same_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.we && mreq.re |-> mreq.waddr != mreq.raddr)
    else $error("read and write of the same bitmap word in one cycle");

  a_find_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OP_FIND_LO || op_q == OP_FIND_HI) && state_q == ST_SWEEP |-> !mreq.we)
    else $error("find transaction wrote the bitmap");

  a_found_only_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && res_q.found |-> (op_q == OP_FIND_LO || op_q == OP_FIND_HI))
    else $error("found flag on a non-find transaction");

  a_pend_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_SWEEP)
    else $error("read data pending outside the sweep");

  a_write_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mreq.we |-> pend_q)
    else $error("bitmap write without read data");

endmodule
